[hdl/cveu_pkg.sv]
// cveu_pkg: types, codes and saturation helpers for the complex vector element unit
// no dependencies; imported by every module of the block

package cveu_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned AccW   = 48;
    localparam int unsigned TermW  = 50;
    localparam int unsigned SumW   = 52;
    localparam int unsigned ModeW  = 4;
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [ModeW-1:0] {
        MODE_DOT      = 4'd0,
        MODE_CONJ_DOT = 4'd1,
        MODE_AXPY     = 4'd2,
        MODE_UPDATE2  = 4'd3,
        MODE_COMBINE  = 4'd4,
        MODE_COMBINE2 = 4'd5,
        MODE_COPY     = 4'd6,
        MODE_SCALE    = 4'd7,
        MODE_ADD      = 4'd8,
        MODE_SUB      = 4'd9,
        MODE_ZERO     = 4'd10,
        MODE_NEGATE   = 4'd11
    } t_mode;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MODE      = 3'd0,
        CFG_COEF_A_RE = 3'd1,
        CFG_COEF_A_IM = 3'd2,
        CFG_COEF_B_RE = 3'd3,
        CFG_COEF_B_IM = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DataW-1:0] first_re;
        logic signed [DataW-1:0] first_im;
        logic signed [DataW-1:0] second_re;
        logic signed [DataW-1:0] second_im;
        logic signed [DataW-1:0] third_re;
        logic signed [DataW-1:0] third_im;
        logic                    last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0] out_re;
        logic signed [DataW-1:0] out_im;
        logic signed [AccW-1:0]  sum_re;
        logic signed [AccW-1:0]  sum_im;
        logic                    sum_valid;
    } t_out_item;

    typedef struct packed {
        t_mode                   mode;
        logic signed [DataW-1:0] a_re;
        logic signed [DataW-1:0] a_im;
        logic signed [DataW-1:0] b_re;
        logic signed [DataW-1:0] b_im;
    } t_cfg;

    localparam logic signed [SumW-1:0] Max32 = SumW'(64'sh7FFF_FFFF);
    localparam logic signed [SumW-1:0] Min32 = -SumW'(64'sh8000_0000);
    localparam logic signed [AccW:0]   Max48 = (AccW+1)'(64'sh7FFF_FFFF_FFFF);
    localparam logic signed [AccW:0]   Min48 = -(AccW+1)'(64'sh8000_0000_0000);

    function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] x);
        logic signed [DataW-1:0] r;
        if (x > Max32) begin
            r = Max32[DataW-1:0];
        end else if (x < Min32) begin
            r = Min32[DataW-1:0];
        end else begin
            r = x[DataW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [AccW-1:0] sat48(input logic signed [AccW:0] x);
        logic signed [AccW-1:0] r;
        if (x > Max48) begin
            r = Max48[AccW-1:0];
        end else if (x < Min48) begin
            r = Min48[AccW-1:0];
        end else begin
            r = x[AccW-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/complex_vector_element_unit.sv]
// Complex vector element unit: Q16.16 complex dot and conjugate dot, axpy, update2,
// combine, combine2, copy, scale, add, sub, zero and negate over a stream. One item is
// taken per clock while the output is not stalled; it is held in the input register,
// then passes the multiply, sum and accumulate logic into the result register.
// The rate is one item per cycle while the output is not stalled, set by the single
// multiply-accumulate stage that also updates the 48-bit dot accumulator. Configuration
// writes always complete at once and are meant to happen between passes.
// Depends on cveu_pkg and cveu_elem.

module complex_vector_element_unit
    import cveu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [DataW-1:0]    i_cfg_data
);

    t_cfg                   r_cfg;
    t_in_item               r_in;
    logic                   r_in_valid;
    t_out_item              r_out;
    logic                   r_out_valid;
    logic signed [AccW-1:0] r_acc_re, r_acc_im;

    t_out_item              n_out;
    logic signed [AccW-1:0] n_acc_re, n_acc_im;
    logic                   advance;
    logic                   in_take;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    cveu_elem u_elem (
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .i_acc_re (r_acc_re),
        .i_acc_im (r_acc_im),
        .o_res    (n_out),
        .o_acc_re (n_acc_re),
        .o_acc_im (n_acc_im)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '{mode: MODE_DOT, default: '0};
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_acc_re <= n_acc_re;
                    r_acc_im <= n_acc_im;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MODE:      r_cfg.mode <= t_mode'(i_cfg_data[ModeW-1:0]);
                    CFG_COEF_A_RE: r_cfg.a_re <= i_cfg_data;
                    CFG_COEF_A_IM: r_cfg.a_im <= i_cfg_data;
                    CFG_COEF_B_RE: r_cfg.b_re <= i_cfg_data;
                    CFG_COEF_B_IM: r_cfg.b_im <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

[hdl/cveu_cmul.sv]
// cveu_cmul: complex multiplier, each real product truncated toward minus infinity
// depends on cveu_pkg for widths

module cveu_cmul
    import cveu_pkg::*;
(
    input  logic signed [DataW:0]   i_x_re,
    input  logic signed [DataW:0]   i_x_im,
    input  logic signed [DataW-1:0] i_y_re,
    input  logic signed [DataW-1:0] i_y_im,
    output logic signed [TermW-1:0] o_re,
    output logic signed [TermW-1:0] o_im
);

    localparam int unsigned ProdW = 2 * DataW + 1;

    logic signed [ProdW-1:0] m_rr, m_ii, m_ri, m_ir;
    logic signed [TermW-2:0] t_rr, t_ii, t_ri, t_ir;

    assign m_rr = i_x_re * i_y_re;
    assign m_ii = i_x_im * i_y_im;
    assign m_ri = i_x_re * i_y_im;
    assign m_ir = i_x_im * i_y_re;

    // drop 16 fraction bits, floor
    assign t_rr = m_rr[ProdW-1:16];
    assign t_ii = m_ii[ProdW-1:16];
    assign t_ri = m_ri[ProdW-1:16];
    assign t_ir = m_ir[ProdW-1:16];

    assign o_re = {t_rr[TermW-2], t_rr} - {t_ii[TermW-2], t_ii};
    assign o_im = {t_ri[TermW-2], t_ri} + {t_ir[TermW-2], t_ir};

endmodule

[hdl/cveu_elem.sv]
// cveu_elem: one item's arithmetic, operand select, sums, saturation and accumulate
// depends on cveu_pkg and cveu_cmul

module cveu_elem
    import cveu_pkg::*;
(
    input  t_cfg                   i_cfg,
    input  t_in_item               i_item,
    input  logic signed [AccW-1:0] i_acc_re,
    input  logic signed [AccW-1:0] i_acc_im,
    output t_out_item              o_res,
    output logic signed [AccW-1:0] o_acc_re,
    output logic signed [AccW-1:0] o_acc_im
);

    logic signed [DataW:0]   x0_re, x0_im;
    logic signed [DataW-1:0] y0_re, y0_im;
    logic signed [TermW-1:0] p_re, p_im, q_re, q_im;
    logic signed [SumW-1:0]  f_re, f_im, s_re, s_im;
    logic signed [SumW-1:0]  pw_re, pw_im, qw_re, qw_im;
    logic signed [SumW-1:0]  r_re, r_im;
    logic signed [AccW:0]    a_re, a_im;
    logic signed [AccW-1:0]  sat_re, sat_im;
    logic                    is_dot;

    // operand select for the first multiplier
    always_comb begin
        x0_re = {i_cfg.a_re[DataW-1], i_cfg.a_re};
        x0_im = {i_cfg.a_im[DataW-1], i_cfg.a_im};
        y0_re = i_item.second_re;
        y0_im = i_item.second_im;
        case (i_cfg.mode)
            MODE_DOT: begin
                x0_re = {i_item.first_re[DataW-1], i_item.first_re};
                x0_im = {i_item.first_im[DataW-1], i_item.first_im};
            end
            MODE_CONJ_DOT: begin
                x0_re = {i_item.first_re[DataW-1], i_item.first_re};
                x0_im = -{i_item.first_im[DataW-1], i_item.first_im};
            end
            MODE_COMBINE: begin
                y0_re = i_item.third_re;
                y0_im = i_item.third_im;
            end
            MODE_SCALE: begin
                x0_re = {i_item.first_re[DataW-1], i_item.first_re};
                x0_im = {i_item.first_im[DataW-1], i_item.first_im};
                y0_re = i_cfg.a_re;
                y0_im = i_cfg.a_im;
            end
            default: begin
            end
        endcase
    end

    cveu_cmul u_mul0 (
        .i_x_re (x0_re),
        .i_x_im (x0_im),
        .i_y_re (y0_re),
        .i_y_im (y0_im),
        .o_re   (p_re),
        .o_im   (p_im)
    );

    cveu_cmul u_mul1 (
        .i_x_re ({i_cfg.b_re[DataW-1], i_cfg.b_re}),
        .i_x_im ({i_cfg.b_im[DataW-1], i_cfg.b_im}),
        .i_y_re (i_item.third_re),
        .i_y_im (i_item.third_im),
        .o_re   (q_re),
        .o_im   (q_im)
    );

    assign f_re  = SumW'(i_item.first_re);
    assign f_im  = SumW'(i_item.first_im);
    assign s_re  = SumW'(i_item.second_re);
    assign s_im  = SumW'(i_item.second_im);
    assign pw_re = SumW'(p_re);
    assign pw_im = SumW'(p_im);
    assign qw_re = SumW'(q_re);
    assign qw_im = SumW'(q_im);

    always_comb begin
        r_re   = '0;
        r_im   = '0;
        is_dot = 1'b0;
        case (i_cfg.mode)
            MODE_DOT, MODE_CONJ_DOT: begin
                is_dot = 1'b1;
            end
            MODE_AXPY: begin
                r_re = f_re + pw_re;
                r_im = f_im + pw_im;
            end
            MODE_UPDATE2: begin
                r_re = f_re + pw_re + qw_re;
                r_im = f_im + pw_im + qw_im;
            end
            MODE_COMBINE: begin
                r_re = s_re + pw_re;
                r_im = s_im + pw_im;
            end
            MODE_COMBINE2: begin
                r_re = pw_re + qw_re;
                r_im = pw_im + qw_im;
            end
            MODE_COPY: begin
                r_re = s_re;
                r_im = s_im;
            end
            MODE_SCALE: begin
                r_re = pw_re;
                r_im = pw_im;
            end
            MODE_ADD: begin
                r_re = f_re + s_re;
                r_im = f_im + s_im;
            end
            MODE_SUB: begin
                r_re = f_re - s_re;
                r_im = f_im - s_im;
            end
            MODE_NEGATE: begin
                r_re = -f_re;
                r_im = -f_im;
            end
            default: begin
            end
        endcase
    end

    // dot accumulate
    assign a_re   = (AccW+1)'(i_acc_re) + (AccW+1)'(p_re);
    assign a_im   = (AccW+1)'(i_acc_im) + (AccW+1)'(p_im);
    assign sat_re = sat48(a_re);
    assign sat_im = sat48(a_im);

    always_comb begin
        o_res.out_re    = sat32(r_re);
        o_res.out_im    = sat32(r_im);
        o_res.sum_re    = '0;
        o_res.sum_im    = '0;
        o_res.sum_valid = 1'b0;
        o_acc_re        = i_acc_re;
        o_acc_im        = i_acc_im;
        if (is_dot) begin
            if (i_item.last_element) begin
                o_res.sum_re    = sat_re;
                o_res.sum_im    = sat_im;
                o_res.sum_valid = 1'b1;
                o_acc_re        = '0;
                o_acc_im        = '0;
            end else begin
                o_acc_re = sat_re;
                o_acc_im = sat_im;
            end
        end
    end

endmodule

[hdl/cveu_chk.sv]
// cveu_chk: port-level checks on the complex vector element unit
// depends on cveu_pkg; bound to complex_vector_element_unit

module cveu_chk
    import cveu_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input t_out_item           o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // free output side never backs up the input
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && i_out_stall) |-> !o_in_stall)
        else $error("input stalled with output free");

    // dot sum only on a final dot item
    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.sum_valid |->
            o_out_item.sum_re == '0 && o_out_item.sum_im == '0)
        else $error("sum fields nonzero without sum_valid");

    a_dot_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.sum_valid |->
            o_out_item.out_re == '0 && o_out_item.out_im == '0)
        else $error("element fields nonzero on a dot result");

endmodule

bind complex_vector_element_unit cveu_chk u_cveu_chk (.*);

[tb/sv/complex_vector_element_unit_tb.sv]
// complex_vector_element_unit_tb: self-checking bench for the complex vector element unit
// directed table of edge cases, then randomized passes with random idling on both sides
// depends on cveu_pkg and the complex_vector_element_unit rtl

module complex_vector_element_unit_tb;
    import cveu_pkg::*;

    localparam int HalfPeriod = 6;
    localparam int TimeoutCycles = 600_000;
    localparam int ItemTarget = 900;
    localparam int MaxWait = 18;
    localparam int NumRegs = CFG_COEF_B_IM + 1;
    localparam int PrintCap = 60;

    localparam logic [ModeW-1:0] ModeSpareFirst = 4'd12;
    localparam logic [ModeW-1:0] ModeSpareLast  = 4'd15;

    localparam logic [DataW-1:0] WordMax = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] WordMin = 32'h8000_0000;
    localparam logic [DataW-1:0] One     = 32'h0001_0000;
    localparam logic [DataW-1:0] Two     = 32'h0002_0000;
    localparam logic [DataW-1:0] Half    = 32'h0000_8000;

    localparam longint Top32 = 64'sd2147483647;
    localparam longint Bot32 = -64'sd2147483648;
    localparam longint Top48 = 64'sd140737488355327;
    localparam longint Bot48 = -64'sd140737488355328;

    typedef logic [DataW-1:0] t_reg_file [NumRegs];

    typedef struct packed {
        logic [DataW-1:0] mode_w;
        logic [DataW-1:0] a_re;
        logic [DataW-1:0] a_im;
        logic [DataW-1:0] b_re;
        logic [DataW-1:0] b_im;
        t_in_item         item;
        logic             typed;
        t_out_item        result;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = CFG_MODE;
    logic [DataW-1:0]    i_cfg_data = '0;

    logic                row_typed = 1'b0;
    t_out_item           row_result = '0;

    // model of the block as seen by the checker
    logic [ModeW-1:0]    cfg_mode = MODE_DOT;
    longint              coef_ar = 0, coef_ai = 0, coef_br = 0, coef_bi = 0;
    longint              dot_re = 0, dot_im = 0;
    t_out_item           awaited_results[$];

    t_reg_file           reg_image = '{default: '0};
    t_row                stim_table[$];
    int                  mismatches = 0;
    int                  items_sent = 0;
    int                  sums_seen = 0;
    int                  settings_count = 0;
    int                  stall_left = 0;
    bit                  in_calm = 1'b0;
    bit                  out_calm = 1'b0;

    complex_vector_element_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(HalfPeriod) i_clk = 1'b1;
        #(HalfPeriod) i_clk = 1'b0;
    end

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // q16.16 product, low 16 bits dropped toward minus infinity
    function automatic longint trunc_mul(input longint x, input longint y);
        return (x * y) >>> 16;
    endfunction

    function automatic void cmul(input longint xr, xi, yr, yi, output longint re, im);
        re = trunc_mul(xr, yr) - trunc_mul(xi, yi);
        im = trunc_mul(xr, yi) + trunc_mul(xi, yr);
    endfunction

    function automatic t_out_item vector_op_result(input t_in_item it);
        longint fr, fi, sr, si, tr, ti, pr, pi, qr, qi, rr, ri;
        t_out_item res;
        fr = it.first_re;  fi = it.first_im;
        sr = it.second_re; si = it.second_im;
        tr = it.third_re;  ti = it.third_im;
        rr = 0; ri = 0;
        res = '0;
        case (cfg_mode)
            MODE_DOT, MODE_CONJ_DOT: begin
                cmul(fr, (cfg_mode == MODE_CONJ_DOT) ? -fi : fi, sr, si, pr, pi);
                dot_re = clamp(dot_re + pr, Bot48, Top48);
                dot_im = clamp(dot_im + pi, Bot48, Top48);
                if (it.last_element) begin
                    res.sum_re = dot_re[AccW-1:0];
                    res.sum_im = dot_im[AccW-1:0];
                    res.sum_valid = 1'b1;
                    dot_re = 0;
                    dot_im = 0;
                end
            end
            MODE_AXPY: begin
                cmul(coef_ar, coef_ai, sr, si, pr, pi);
                rr = fr + pr; ri = fi + pi;
            end
            MODE_UPDATE2: begin
                cmul(coef_ar, coef_ai, sr, si, pr, pi);
                cmul(coef_br, coef_bi, tr, ti, qr, qi);
                rr = fr + pr + qr; ri = fi + pi + qi;
            end
            MODE_COMBINE: begin
                cmul(coef_ar, coef_ai, tr, ti, pr, pi);
                rr = sr + pr; ri = si + pi;
            end
            MODE_COMBINE2: begin
                cmul(coef_ar, coef_ai, sr, si, pr, pi);
                cmul(coef_br, coef_bi, tr, ti, qr, qi);
                rr = pr + qr; ri = pi + qi;
            end
            MODE_COPY: begin
                rr = sr; ri = si;
            end
            MODE_SCALE: cmul(fr, fi, coef_ar, coef_ai, rr, ri);
            MODE_ADD: begin
                rr = fr + sr; ri = fi + si;
            end
            MODE_SUB: begin
                rr = fr - sr; ri = fi - si;
            end
            MODE_NEGATE: begin
                rr = -fr; ri = -fi;
            end
            default: ;
        endcase
        rr = clamp(rr, Bot32, Top32);
        ri = clamp(ri, Bot32, Top32);
        res.out_re = rr[DataW-1:0];
        res.out_im = ri[DataW-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (want !== got) begin
            if (mismatches < PrintCap)
                $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    if (mismatches < PrintCap)
                        $display("%0t unexpected item expected none actual %h", $time,
                                 o_out_item);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("out_re", want.out_re, o_out_item.out_re);
                    check_field("out_im", want.out_im, o_out_item.out_im);
                    check_field("sum_re", want.sum_re, o_out_item.sum_re);
                    check_field("sum_im", want.sum_im, o_out_item.sum_im);
                    check_field("sum_valid", want.sum_valid, o_out_item.sum_valid);
                end
                if (o_out_item.sum_valid === 1'b1) sums_seen++;
                stall_left = out_calm ? 0 : $urandom_range(0, MaxWait);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:      cfg_mode = i_cfg_data[ModeW-1:0];
                    CFG_COEF_A_RE: coef_ar = $signed(i_cfg_data);
                    CFG_COEF_A_IM: coef_ai = $signed(i_cfg_data);
                    CFG_COEF_B_RE: coef_br = $signed(i_cfg_data);
                    CFG_COEF_B_IM: coef_bi = $signed(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                want = vector_op_result(i_in_item);
                awaited_results.push_back(row_typed ? row_result : want);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic t_in_item mk_item(input logic [DataW-1:0] fr, fi, sr, si, tr, ti,
                                         input logic last);
        t_in_item it;
        it.first_re = fr;  it.first_im = fi;
        it.second_re = sr; it.second_im = si;
        it.third_re = tr;  it.third_im = ti;
        it.last_element = last;
        return it;
    endfunction

    function automatic t_out_item mk_res(input logic [DataW-1:0] ore, oim,
                                         input logic [AccW-1:0] sre, sim, input logic v);
        t_out_item r;
        r.out_re = ore; r.out_im = oim;
        r.sum_re = sre; r.sum_im = sim;
        r.sum_valid = v;
        return r;
    endfunction

    function automatic void add_row(input logic [DataW-1:0] m, ar, ai, br, bi,
                                    input t_in_item it, input logic typed,
                                    input t_out_item res);
        t_row r;
        r.mode_w = m;
        r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
        r.item = it;
        r.typed = typed;
        r.result = res;
        stim_table.push_back(r);
    endfunction

    function automatic logic [DataW-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return WordMin;
            1: return WordMax;
            2: return DataW'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
            3: return DataW'(int'($urandom_range(0, 2)) - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_regs(input t_reg_file vals);
        bit busy;
        busy = 1'b0;
        for (int r = 0; r < NumRegs; r++) begin
            if (vals[r] !== reg_image[r]) begin
                if (!busy) begin
                    drain();
                    busy = 1'b1;
                    settings_count++;
                end
                i_cfg_index <= CfgIdxW'(r);
                i_cfg_data <= vals[r];
                i_cfg_valid <= 1'b1;
                do @(posedge i_clk); while (!o_cfg_ready);
                @(negedge i_clk);
                reg_image[r] = vals[r];
            end
        end
        if (busy) i_cfg_valid <= 1'b0;
    endtask

    task automatic send(input t_in_item it, input logic typed, input t_out_item res);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MaxWait);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item <= it;
        row_typed <= typed;
        row_result <= res;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    initial begin
        t_reg_file vals;
        logic [ModeW-1:0] m;
        bit is_dot;
        logic last;
        int n, pick, pass_left;

        pass_left = 0;

        // reset state: plain dot with all coefficients zero
        add_row(MODE_DOT, 0, 0, 0, 0, mk_item(One, 0, Two, 0, 0, 0, 1'b1),
                1'b1, mk_res(0, 0, 48'h2_0000, 0, 1'b1));
        add_row(MODE_DOT, 0, 0, 0, 0,
                mk_item(WordMin, WordMin, WordMin, WordMin, WordMax, WordMin, 1'b0),
                1'b0, '0);
        add_row(MODE_DOT, 0, 0, 0, 0,
                mk_item(WordMin, WordMin, WordMin, WordMin, 0, 0, 1'b1), 1'b0, '0);
        add_row(MODE_CONJ_DOT, 0, 0, 0, 0,
                mk_item(0, WordMin, WordMax, WordMax, 0, 0, 1'b0), 1'b0, '0);
        add_row(MODE_CONJ_DOT, 0, 0, 0, 0,
                mk_item(WordMax, WordMax, WordMax, WordMax, 0, 0, 1'b1), 1'b0, '0);
        add_row(MODE_AXPY, WordMax, WordMin, 0, 0,
                mk_item(WordMax, WordMax, WordMax, WordMin, 0, 0, 1'b1), 1'b0, '0);
        add_row(MODE_AXPY, One, 0, 0, 0, mk_item(1, 2, 3, 4, 0, 0, 1'b0),
                1'b1, mk_res(4, 6, 0, 0, 1'b0));
        add_row(MODE_UPDATE2, WordMin, WordMin, WordMin, WordMin,
                mk_item(WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, 1'b0),
                1'b0, '0);
        add_row(MODE_UPDATE2, Half, -One, WordMax, Two,
                mk_item(-Two, One, 32'h1234_5678, -32'h0765_4321, -1, Half, 1'b0),
                1'b0, '0);
        add_row(MODE_COMBINE, WordMax, WordMax, WordMax, Two,
                mk_item(0, 0, WordMin, WordMax, WordMax, WordMin, 1'b1), 1'b0, '0);
        add_row(MODE_COMBINE2, WordMin, WordMax, WordMax, WordMin,
                mk_item(0, 0, WordMax, WordMin, WordMin, WordMax, 1'b0), 1'b0, '0);
        add_row(MODE_COPY, WordMin, WordMax, WordMax, WordMin,
                mk_item(WordMax, WordMax, WordMin, WordMax, One, One, 1'b0),
                1'b1, mk_res(WordMin, WordMax, 0, 0, 1'b0));
        add_row(MODE_SCALE, WordMin, WordMin, WordMax, WordMin,
                mk_item(WordMin, WordMin, 0, 0, 0, 0, 1'b0),
                1'b1, mk_res(0, WordMax, 0, 0, 1'b0));
        // truncation of a negative product rounds down
        add_row(MODE_SCALE, Half, 0, WordMax, WordMin,
                mk_item(-1, 0, WordMax, WordMax, 0, 0, 1'b1),
                1'b1, mk_res(-1, 0, 0, 0, 1'b0));
        add_row(MODE_ADD, Half, 0, WordMax, WordMin,
                mk_item(WordMax, WordMin, WordMax, WordMin, 0, 0, 1'b0),
                1'b1, mk_res(WordMax, WordMin, 0, 0, 1'b0));
        add_row(MODE_SUB, Half, 0, WordMax, WordMin,
                mk_item(WordMin, WordMax, WordMax, WordMin, 0, 0, 1'b0),
                1'b1, mk_res(WordMin, WordMax, 0, 0, 1'b0));
        add_row(MODE_ZERO, Half, 0, WordMax, WordMin,
                mk_item(WordMax, WordMin, WordMax, WordMin, WordMax, WordMin, 1'b1),
                1'b1, mk_res(0, 0, 0, 0, 1'b0));
        // negating the most negative value saturates
        add_row(MODE_NEGATE, Half, 0, WordMax, WordMin,
                mk_item(WordMin, WordMax, 0, 0, 0, 0, 1'b0),
                1'b1, mk_res(WordMax, -WordMax, 0, 0, 1'b0));
        add_row(ModeSpareFirst, Half, 0, WordMax, WordMin,
                mk_item(WordMax, WordMax, WordMax, WordMax, WordMax, WordMax, 1'b1),
                1'b1, mk_res(0, 0, 0, 0, 1'b0));
        add_row(ModeSpareLast, Half, 0, WordMax, WordMin,
                mk_item(WordMin, WordMin, WordMin, WordMin, WordMin, WordMin, 1'b0),
                1'b1, mk_res(0, 0, 0, 0, 1'b0));
        // open pass survives an element mode in between
        add_row(MODE_DOT, Half, 0, WordMax, WordMin,
                mk_item(One, One, One, 0, 0, 0, 1'b0), 1'b0, '0);
        add_row(MODE_ADD, Half, 0, WordMax, WordMin, mk_item(1, 1, 1, 1, 0, 0, 1'b1),
                1'b1, mk_res(2, 2, 0, 0, 1'b0));
        add_row(MODE_CONJ_DOT, Half, 0, WordMax, WordMin,
                mk_item(One, One, One, 0, 0, 0, 1'b1),
                1'b1, mk_res(0, 0, 48'h2_0000, 0, 1'b1));

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[i]) begin
            vals[CFG_MODE] = stim_table[i].mode_w;
            vals[CFG_COEF_A_RE] = stim_table[i].a_re;
            vals[CFG_COEF_A_IM] = stim_table[i].a_im;
            vals[CFG_COEF_B_RE] = stim_table[i].b_re;
            vals[CFG_COEF_B_IM] = stim_table[i].b_im;
            load_regs(vals);
            send(stim_table[i].item, stim_table[i].typed, stim_table[i].result);
        end

        while (items_sent < stim_table.size() + ItemTarget) begin
            vals = reg_image;
            pick = $urandom_range(0, 9);
            if (pick < 3)
                m = $urandom_range(MODE_DOT, MODE_CONJ_DOT);
            else if (pick == 3)
                m = $urandom_range(ModeSpareFirst, ModeSpareLast);
            else
                m = $urandom_range(MODE_AXPY, MODE_NEGATE);
            vals[CFG_MODE] = ($urandom << ModeW) | DataW'(m);
            for (int r = CFG_COEF_A_RE; r <= CFG_COEF_B_IM; r++)
                if ($urandom_range(0, 1)) vals[r] = rand_word();
            load_regs(vals);
            in_calm = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            is_dot = (m == MODE_DOT || m == MODE_CONJ_DOT);
            n = $urandom_range(20, 60);
            for (int k = 0; k < n; k++) begin
                if (is_dot) begin
                    if (pass_left == 0) pass_left = $urandom_range(1, 12);
                    pass_left--;
                    last = (pass_left == 0);
                    // occasional broken pass
                    if ($urandom_range(0, 15) == 0) last = ~last;
                end else begin
                    last = $urandom_range(0, 1);
                end
                send(mk_item(rand_word(), rand_word(), rand_word(), rand_word(),
                             rand_word(), rand_word(), last), 1'b0, '0);
                if ($urandom_range(0, 63) == 0) drain();
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("run covered %0d items under %0d register settings", items_sent,
                 settings_count);
        $display("%0d dot sums closed, %0d field mismatches", sums_seen, mismatches);
        if (mismatches == 0) begin
            $display("complex_vector_element_unit: match");
        end else begin
            $display("complex_vector_element_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #(2 * HalfPeriod * TimeoutCycles);
        $display("timeout with %0d items outstanding", awaited_results.size());
        $display("complex_vector_element_unit: mismatch");
        $finish;
    end

endmodule
